FILE: sv/dynamic_priority_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// Dynamic priority scheduler assertion macros
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: sv/dps_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int PRIO_W    = 12;
    localparam int TIME_W    = 10;
    localparam int SLOT_IN_W = 3;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic load_we;
        logic scan_clear;
        logic scan_step;
        logic commit;
    } dps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dps_sts_t;

endpackage

FILE: sv/dps_ctrl.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler controller
// Sequences the accept, slot scan and write-back phases of each tick word.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_top_assert.svh"

module dps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic              m_ready,
    input  dps_pkg::dps_sts_t sts,
    output dps_pkg::dps_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_SPARE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == dps_pkg::OP_TICK) begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DPS_ASSERT_NEVER(a_commit_vs_load, aclk, aresetn, cmd.commit && cmd.load_we, "Commit and load in one cycle")
    `DPS_ASSERT(a_commit_to_idle, aclk, aresetn, cmd.commit |=> (state_reg == S_IDLE), "Commit did not return to idle")
    `DPS_ASSERT(a_scan_to_write, aclk, aresetn, (cmd.scan_step && sts.scan_last) |=> (state_reg == S_WRITE), "Scan end did not reach write-back")

endmodule

FILE: sv/dps_datapath.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler datapath
// Slot tables, live flags, priority scan and the output word register.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_top_assert.svh"

module dps_datapath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  dps_pkg::dps_cmd_t                        cmd,
    output dps_pkg::dps_sts_t                        sts,
    input  logic [dps_pkg::SLOT_IN_W-1:0]            s_slot,
    input  logic signed [dps_pkg::PRIO_W-1:0]        s_load_priority,
    input  logic [dps_pkg::TIME_W-1:0]               s_load_time,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [dps_pkg::SLOT_IN_W-1:0]            m_ran_slot,
    output logic [dps_pkg::TIME_W-1:0]               m_remaining_after,
    output logic signed [dps_pkg::PRIO_W-1:0]        m_priority_after,
    output logic                                     m_finished,
    output logic                                     m_idle
);

    logic signed [dps_pkg::PRIO_W-1:0] prio_tbl_reg [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::TIME_W-1:0]        rem_tbl_reg  [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::NUM_SLOTS-1:0]     live_reg;

    logic [dps_pkg::SLOT_W-1:0]        scan_idx_reg;
    logic                              found_reg;
    logic [dps_pkg::SLOT_W-1:0]        best_idx_reg;
    logic signed [dps_pkg::PRIO_W-1:0] best_prio_reg;
    logic [dps_pkg::TIME_W-1:0]        best_rem_reg;

    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [dps_pkg::SLOT_IN_W-1:0]     m_ran_slot_reg;
    logic [dps_pkg::TIME_W-1:0]        m_rem_reg;
    logic signed [dps_pkg::PRIO_W-1:0] m_prio_reg;
    logic                              m_finished_reg;
    logic                              m_idle_reg;

    logic [dps_pkg::SLOT_W-1:0]        load_idx;
    logic                              load_ok;
    logic signed [dps_pkg::PRIO_W-1:0] cur_prio;
    logic [dps_pkg::TIME_W-1:0]        cur_rem;
    logic                              take;
    logic [dps_pkg::TIME_W-1:0]        rem_new;
    logic signed [dps_pkg::PRIO_W-1:0] prio_new;
    logic                              done;

    assign load_idx = dps_pkg::SLOT_W'(s_slot);
    assign load_ok  = (int'(s_slot) < dps_pkg::NUM_SLOTS);
    assign cur_prio = prio_tbl_reg[scan_idx_reg];
    assign cur_rem  = rem_tbl_reg[scan_idx_reg];
    assign take     = live_reg[scan_idx_reg] && (!found_reg || (cur_prio > best_prio_reg));

    assign rem_new  = (best_rem_reg != '0) ? best_rem_reg - 1'b1 : best_rem_reg;
    assign prio_new = (best_prio_reg != dps_pkg::PRIO_MIN) ?
                      best_prio_reg - dps_pkg::PRIO_W'(1) : best_prio_reg;
    assign done     = (rem_new == '0);

    assign sts.scan_last = (scan_idx_reg == dps_pkg::SLOT_W'(dps_pkg::NUM_SLOTS - 1));
    assign sts.out_busy  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_we && load_ok) begin
            prio_tbl_reg[load_idx] <= s_load_priority;
            rem_tbl_reg[load_idx]  <= s_load_time;
        end else if (cmd.commit && found_reg) begin
            prio_tbl_reg[best_idx_reg] <= prio_new;
            rem_tbl_reg[best_idx_reg]  <= rem_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else if (cmd.load_we && load_ok) begin
            live_reg[load_idx] <= (s_load_time != '0);
        end else if (cmd.commit && found_reg) begin
            live_reg[best_idx_reg] <= !done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.scan_clear) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && take) begin
            best_idx_reg  <= scan_idx_reg;
            best_prio_reg <= cur_prio;
            best_rem_reg  <= cur_rem;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (found_reg) begin
                m_ran_slot_reg <= dps_pkg::SLOT_IN_W'(best_idx_reg);
                m_rem_reg      <= rem_new;
                m_prio_reg     <= prio_new;
                m_finished_reg <= done;
                m_idle_reg     <= 1'b0;
            end else begin
                m_ran_slot_reg <= '0;
                m_rem_reg      <= '0;
                m_prio_reg     <= '0;
                m_finished_reg <= 1'b0;
                m_idle_reg     <= 1'b1;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ran_slot        = m_ran_slot_reg;
    assign m_remaining_after = m_rem_reg;
    assign m_priority_after  = m_prio_reg;
    assign m_finished        = m_finished_reg;
    assign m_idle            = m_idle_reg;

    `DPS_ASSERT(a_commit_sets_valid, aclk, aresetn, cmd.commit |=> m_valid_reg, "Commit did not present a word")
    `DPS_ASSERT(a_idle_clean, aclk, aresetn, (m_valid_reg && m_idle_reg) |-> (m_ran_slot_reg == '0 && !m_finished_reg), "Idle word carries slot data")
    `DPS_ASSERT(a_retire_flag, aclk, aresetn, (cmd.commit && found_reg) |=> (live_reg[$past(best_idx_reg)] != m_finished_reg), "Live flag disagrees with finished")

endmodule

FILE: sv/dynamic_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler top level
// Eight process slots; a tick runs the live slot of highest priority.
//
//   Channel  Prefix  Fields
//   input    s_      operation, slot, load_priority, load_time
//   result   m_      ran_slot, remaining_after, priority_after, finished, idle
//
// A load word is taken and gives no result.
// A tick word is accepted, then the slots are scanned in turn and the result
// is written back.
// Reset clears the live flags and the output valid flag; no clearing pass.
// A held result stalls only the write-back of the following tick.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [dps_pkg::SLOT_IN_W-1:0]         s_slot,
    input  logic signed [dps_pkg::PRIO_W-1:0]     s_load_priority,
    input  logic [dps_pkg::TIME_W-1:0]            s_load_time,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dps_pkg::SLOT_IN_W-1:0]         m_ran_slot,
    output logic [dps_pkg::TIME_W-1:0]            m_remaining_after,
    output logic signed [dps_pkg::PRIO_W-1:0]     m_priority_after,
    output logic                                  m_finished,
    output logic                                  m_idle
);

    dps_pkg::dps_cmd_t cmd;
    dps_pkg::dps_sts_t sts;

    dps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    dps_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_slot            (s_slot),
        .s_load_priority   (s_load_priority),
        .s_load_time       (s_load_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ran_slot        (m_ran_slot),
        .m_remaining_after (m_remaining_after),
        .m_priority_after  (m_priority_after),
        .m_finished        (m_finished),
        .m_idle            (m_idle)
    );

endmodule

FILE: verif/dynamic_priority_scheduler_checker.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler result checker
// Watches both channels of the scheduler, keeps its own copy of the slot
// table, works out the report of every accepted tick word and compares each
// accepted result word with the oldest report still outstanding.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_checker
    import dps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_operation,
    input  logic [SLOT_IN_W-1:0]     s_slot,
    input  logic signed [PRIO_W-1:0] s_load_priority,
    input  logic [TIME_W-1:0]        s_load_time,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [SLOT_IN_W-1:0]     m_ran_slot,
    input  logic [TIME_W-1:0]        m_remaining_after,
    input  logic signed [PRIO_W-1:0] m_priority_after,
    input  logic                     m_finished,
    input  logic                     m_idle,
    output int unsigned              mismatches,
    output int unsigned              expected_left
);

    typedef struct packed {
        logic [SLOT_IN_W-1:0]     ran_slot;
        logic [TIME_W-1:0]        time_after;
        logic signed [PRIO_W-1:0] prio_after;
        logic                     finished;
        logic                     idle;
    } tick_report_t;

    bit                       slot_live [NUM_SLOTS];
    logic signed [PRIO_W-1:0] slot_prio [NUM_SLOTS];
    logic [TIME_W-1:0]        slot_time [NUM_SLOTS];
    tick_report_t             tick_reports [$];

    initial begin
        mismatches    = 0;
        expected_left = 0;
    end

    // Runs the live slot of highest priority, the lowest index winning a tie.
    function automatic tick_report_t run_tick();
        int           best;
        tick_report_t rep;
        best = -1;
        rep  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && (best < 0 || slot_prio[i] > slot_prio[best])) begin
                best = i;
            end
        end
        if (best < 0) begin
            rep.idle = 1'b1;
            return rep;
        end
        if (slot_time[best] != '0) begin
            slot_time[best] = slot_time[best] - 1'b1;
        end
        if (slot_prio[best] != PRIO_MIN) begin
            slot_prio[best] = slot_prio[best] - PRIO_W'(1);
        end
        if (slot_time[best] == '0) begin
            slot_live[best] = 1'b0;
        end
        rep.ran_slot   = SLOT_IN_W'(best);
        rep.time_after = slot_time[best];
        rep.prio_after = slot_prio[best];
        rep.finished   = (slot_time[best] == '0);
        return rep;
    endfunction

    always @(posedge aclk) begin : watch
        tick_report_t got;
        tick_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_live[i] = 1'b0;
            end
            tick_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_ran_slot, m_remaining_after, m_priority_after, m_finished, m_idle};
                if (tick_reports.size() == 0) begin
                    $display("%0t: unexpected result word slot=%0d rem=%0d prio=%0d fin=%0b idle=%0b",
                             $realtime, got.ran_slot, got.time_after, got.prio_after,
                             got.finished, got.idle);
                    mismatches++;
                end else begin
                    want = tick_reports.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected slot=%0d rem=%0d prio=%0d fin=%0b idle=%0b",
                                 $realtime, want.ran_slot, want.time_after, want.prio_after,
                                 want.finished, want.idle);
                        $display("%0t:                  actual slot=%0d rem=%0d prio=%0d fin=%0b idle=%0b",
                                 $realtime, got.ran_slot, got.time_after, got.prio_after,
                                 got.finished, got.idle);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_TICK) begin
                    tick_reports.push_back(run_tick());
                end else if (int'(s_slot) < NUM_SLOTS) begin
                    slot_prio[s_slot] = s_load_priority;
                    slot_time[s_slot] = s_load_time;
                    slot_live[s_slot] = (s_load_time != '0);
                end
            end
        end
        expected_left = tick_reports.size();
    end

endmodule

FILE: verif/dynamic_priority_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler testbench
// Drives load and tick words into the scheduler: a directed opening covering
// idle ticks, ties, saturation, zero-time loads and overwrites, then random
// load and tick sequences with random gaps and stalls on both channels, a
// long stall of the result channel and a full drain. The checker beside the
// block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_top_tb;
    import dps_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 450;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4 * (NUM_SLOTS + 2);
    localparam int CYCLE_LIMIT  = 200000;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic                     s_operation     = 1'b0;
    logic [SLOT_IN_W-1:0]     s_slot          = '0;
    logic signed [PRIO_W-1:0] s_load_priority = '0;
    logic [TIME_W-1:0]        s_load_time     = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [SLOT_IN_W-1:0]     m_ran_slot;
    logic [TIME_W-1:0]        m_remaining_after;
    logic signed [PRIO_W-1:0] m_priority_after;
    logic                     m_finished;
    logic                     m_idle;

    int unsigned mismatches;
    int unsigned expected_left;
    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;
    bit          hold_req    = 1'b0;
    bit          no_gaps     = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    dynamic_priority_scheduler_top DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_slot            (s_slot),
        .s_load_priority   (s_load_priority),
        .s_load_time       (s_load_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ran_slot        (m_ran_slot),
        .m_remaining_after (m_remaining_after),
        .m_priority_after  (m_priority_after),
        .m_finished        (m_finished),
        .m_idle            (m_idle)
    );

    dynamic_priority_scheduler_checker result_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_slot            (s_slot),
        .s_load_priority   (s_load_priority),
        .s_load_time       (s_load_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ran_slot        (m_ran_slot),
        .m_remaining_after (m_remaining_after),
        .m_priority_after  (m_priority_after),
        .m_finished        (m_finished),
        .m_idle            (m_idle),
        .mismatches        (mismatches),
        .expected_left     (expected_left)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL dynamic_priority_scheduler_top");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Mostly full range, with narrow bands that force ties and saturation.
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int v;
        case ($urandom_range(0, 3))
            0, 1:    v = $urandom;
            2:       v = int'($urandom_range(0, 6)) - 3;
            default: v = -2048 + int'($urandom_range(0, 8));
        endcase
        return PRIO_W'(v);
    endfunction

    // Short run times so that slots retire often.
    function automatic logic [TIME_W-1:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return TIME_W'($urandom_range(1, 4));
        end else if (r < 90) begin
            return '0;
        end
        return TIME_W'($urandom_range(0, 1023));
    endfunction

    task automatic offer_word(input op_t op, input logic [SLOT_IN_W-1:0] slot,
                              input logic signed [PRIO_W-1:0] prio,
                              input logic [TIME_W-1:0] ticks);
        int gap;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_slot          <= slot;
        s_load_priority <= prio;
        s_load_time     <= ticks;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
    endtask

    // Result side: random ready and stall runs, plus one long hold-off on request.
    initial begin : result_side
        int ready_run;
        int stall_run;
        int r;
        ready_run = 0;
        stall_run = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (ready_run > 0) begin
                m_ready <= 1'b1;
                ready_run--;
            end else if (stall_run > 0) begin
                m_ready <= 1'b0;
                stall_run--;
            end else begin
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 150)
                                                         : $urandom_range(0, 11);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    stall_run = 0;
                end else if (r < 90) begin
                    stall_run = $urandom_range(1, 3);
                end else begin
                    stall_run = $urandom_range(8, 30);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int  first_random;
        int  progress;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd0, 2047, 1023);
        offer_word(OP_TICK, 3'd6, -1, 1023);
        offer_word(OP_LOAD, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd7, PRIO_MIN, 3);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd2, 5, 2);
        offer_word(OP_LOAD, 3'd5, 5, 2);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd7, -1, 1);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd3, PRIO_W'(12'h555), TIME_W'(10'h2aa));
        offer_word(OP_LOAD, 3'd4, PRIO_W'(12'haaa), TIME_W'(10'h155));
        offer_word(OP_LOAD, 3'd1, -2047, 1);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_LOAD, 3'd3, 0, 0);
        offer_word(OP_LOAD, 3'd4, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);
        offer_word(OP_TICK, 3'd0, 0, 0);

        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            progress = words_sent - first_random;
            no_gaps  = (progress >= 150 && progress < 220);
            if (!hold_done && progress >= 150) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && progress >= 300) begin
                drain_done = 1'b1;
                wait_for_drain();
            end
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    offer_word(OP_LOAD, SLOT_IN_W'($urandom_range(0, NUM_SLOTS - 1)),
                               pick_prio(), pick_ticks());
                end
                repeat ($urandom_range(1, 8)) begin
                    offer_word(OP_TICK, SLOT_IN_W'($urandom), PRIO_W'($urandom),
                               TIME_W'($urandom));
                end
            end else begin
                offer_word(op_t'($urandom_range(0, 1)), SLOT_IN_W'($urandom),
                           PRIO_W'($urandom), TIME_W'($urandom));
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_left == 0) begin
            $display("PASS dynamic_priority_scheduler_top");
        end else begin
            $display("FAIL dynamic_priority_scheduler_top");
        end
        $finish;
    end

endmodule

FILE: dynamic_priority_scheduler_top.f
+incdir+sv
sv/dps_pkg.sv
sv/dps_ctrl.sv
sv/dps_datapath.sv
sv/dynamic_priority_scheduler_top.sv
verif/dynamic_priority_scheduler_checker.sv
verif/dynamic_priority_scheduler_top_tb.sv
